/* rtl/rsnp_pkg.sv */
// ----------------------------------------------------------------------------
// rsnp_pkg
// Shared types and constants of the nearest ray-sphere pick block.
// ----------------------------------------------------------------------------
package rsnp_pkg;

   localparam int MAX_POINTS  = 256;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int AXES        = 3;
   localparam int SQRT_STEPS  = 37;
   localparam int STEP_W      = $clog2(SQRT_STEPS);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_RADIUS_SQ = 3'd6;

   localparam logic [17:0] DIR_Z_RESET  = 18'h30000;   // -1.0
   localparam logic [31:0] RADIUS_RESET = 32'd10486;   // 0.4^2

   typedef struct packed {
      logic       load;
      logic       acc;
      logic [1:0] axis;
      logic       bsq;
      logic       det;
      logic       sqrt;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_busy;
   } status_type;

endpackage

/* rtl/rsnp_ctrl.sv */
// ----------------------------------------------------------------------------
// rsnp_ctrl
// Sequencer: accept, three dot-product beats, b squared, det, root, update.
// ----------------------------------------------------------------------------
module rsnp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rsnp_pkg::status_type status,
   output rsnp_pkg::cmd_type    cmd
);

   localparam int STEP_W = rsnp_pkg::STEP_W;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ACC  = 7'b0000010,
      ST_BSQ  = 7'b0000100,
      ST_DET  = 7'b0001000,
      ST_SQRT = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_WAIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [rsnp_pkg::STEP_W-1:0] step_ff, step_in;
   logic fin_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign fin_ok     = !status.last || !status.out_busy;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               axis_in  = '0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (axis_ff == 2'(rsnp_pkg::AXES - 1)) begin
               state_in = ST_BSQ;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_BSQ: begin
            cmd.bsq  = 1'b1;
            state_in = ST_DET;
         end
         ST_DET: begin
            cmd.det  = 1'b1;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt = 1'b1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(rsnp_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN, ST_WAIT: begin
            if (fin_ok) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* rtl/rsnp_dp.sv */
// ----------------------------------------------------------------------------
// rsnp_dp
// Datapath: ray registers, offsets, dot products, det, bit-serial root,
// nearest-hit tracking and the result register.
// ----------------------------------------------------------------------------
module rsnp_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rsnp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rsnp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [95:0]                         req_tdata,
   input  logic                                req_tlast,
   input  rsnp_pkg::cmd_type                   cmd,
   output rsnp_pkg::status_type                status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int IW = rsnp_pkg::IDX_W;

   // configuration
   logic signed [31:0] org_ff [rsnp_pkg::AXES];
   logic signed [17:0] dir_ff [rsnp_pkg::AXES];
   logic        [31:0] rsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= rsnp_pkg::DIR_Z_RESET;
         rsq_ff    <= rsnp_pkg::RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            rsnp_pkg::REG_ORIGIN_X:  org_ff[0] <= csr_wdata;
            rsnp_pkg::REG_ORIGIN_Y:  org_ff[1] <= csr_wdata;
            rsnp_pkg::REG_ORIGIN_Z:  org_ff[2] <= csr_wdata;
            rsnp_pkg::REG_DIR_X:     dir_ff[0] <= csr_wdata[17:0];
            rsnp_pkg::REG_DIR_Y:     dir_ff[1] <= csr_wdata[17:0];
            rsnp_pkg::REG_DIR_Z:     dir_ff[2] <= csr_wdata[17:0];
            rsnp_pkg::REG_RADIUS_SQ: rsq_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-item working registers
   logic signed [32:0] d_ff [rsnp_pkg::AXES];
   logic               last_ff;
   logic [IW-1:0]      idx_ff, cnt_ff;
   logic signed [53:0] bfull_ff;
   logic        [49:0] dd_ff;
   logic        [63:0] bsq_ff;
   logic signed [63:0] det_ff;
   logic        [73:0] rad_ff;
   logic        [39:0] rem_ff;
   logic        [36:0] root_ff;

   // dot-product beat
   logic signed [32:0] d_sel;
   logic signed [17:0] dir_sel;
   logic signed [50:0] dprod;
   logic        [31:0] dmag;
   logic        [63:0] dsq;

   assign d_sel   = d_ff[cmd.axis];
   assign dir_sel = dir_ff[cmd.axis];
   assign dprod   = dir_sel * d_sel;
   assign dmag    = d_sel[32] ? 32'(-d_sel) : d_sel[31:0];
   assign dsq     = dmag * dmag;

   // b and its square (split so the wide multiply stays 32x32)
   logic signed [37:0] b_val;
   logic        [36:0] bmag;
   logic        [4:0]  bh;
   logic        [31:0] bl;
   logic        [63:0] bsq_val;

   assign b_val   = 38'(bfull_ff >>> 16);
   assign bmag    = b_val[37] ? 37'(-b_val) : b_val[36:0];
   assign bh      = bmag[36:32];
   assign bl      = bmag[31:0];
   assign bsq_val = ({54'd0, 10'(bh) * 10'(bh)} << 48)
                    + (({59'd0, bh} * {32'd0, bl}) << 17)
                    + ((64'(bl) * 64'(bl)) >> 16);

   // root step
   logic [39:0] rem_sh, trial;
   logic        take;

   assign rem_sh = {rem_ff[37:0], rad_ff[73:72]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign take   = rem_sh >= trial;

   // distance and compare
   logic signed [38:0] dist_full;
   logic signed [31:0] dist_sat;
   logic               hit, better;
   logic               have_ff;
   logic [IW-1:0]      bidx_ff;
   logic signed [31:0] bdist_ff;
   logic               nh;
   logic [IW-1:0]      nidx;
   logic signed [31:0] ndist;

   assign dist_full = -39'(b_val) - $signed({2'b00, root_ff});
   always_comb begin
      if (dist_full > 39'sd2147483647)       dist_sat = 32'h7fffffff;
      else if (dist_full < -39'sd2147483648) dist_sat = 32'h80000000;
      else                                   dist_sat = dist_full[31:0];
   end
   assign hit    = !det_ff[63];
   assign better = hit && (!have_ff || dist_sat < bdist_ff);
   assign nh     = have_ff || hit;
   assign nidx   = better ? idx_ff : bidx_ff;
   assign ndist  = better ? dist_sat : bdist_ff;

   logic          rv_ff;
   logic          rhit_ff;
   logic [IW-1:0] ridx_ff;
   logic [31:0]   rdist_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < rsnp_pkg::AXES; i++) begin
            d_ff[i] <= 33'(org_ff[i]) - 33'($signed(req_tdata[32*i +: 32]));
         end
         last_ff  <= req_tlast;
         idx_ff   <= cnt_ff;
         bfull_ff <= '0;
         dd_ff    <= '0;
      end
      if (cmd.acc) begin
         bfull_ff <= bfull_ff + 54'(dprod);
         dd_ff    <= dd_ff + 50'(dsq >> 16);
      end
      if (cmd.bsq) begin
         bsq_ff <= bsq_val;
      end
      if (cmd.det) begin
         det_ff  <= $signed(bsq_ff) - $signed({14'd0, dd_ff}) + $signed({32'd0, rsq_ff});
         rad_ff  <= {det_ff_next(bsq_ff, dd_ff, rsq_ff), 16'd0};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= take ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[35:0], take};
      end
      if (cmd.fin && last_ff) begin
         rhit_ff  <= nh;
         ridx_ff  <= nh ? nidx : '0;
         rdist_ff <= nh ? ndist : '0;
      end
   end

   function automatic logic [57:0] det_ff_next(input logic [63:0] s, input logic [49:0] q,
                                               input logic [31:0] r);
      logic [63:0] t;
      t = s - {14'd0, q} + {32'd0, r};
      return t[57:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         have_ff  <= 1'b0;
         bidx_ff  <= '0;
         bdist_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         // a new result may replace one taken at this same edge
         if (cmd.fin && last_ff) begin
            rv_ff <= 1'b1;
         end else if (rv_ff && rsp_tready) begin
            rv_ff <= 1'b0;
         end
         if (cmd.load) begin
            cnt_ff <= cnt_ff + IW'(1);   // wraps at MAX_POINTS
         end
         if (cmd.fin) begin
            if (last_ff) begin
               cnt_ff   <= '0;
               have_ff  <= 1'b0;
               bidx_ff  <= '0;
               bdist_ff <= '0;
            end else begin
               have_ff  <= nh;
               bidx_ff  <= nidx;
               bdist_ff <= ndist;
            end
         end
      end
   end

   assign status.last     = last_ff;
   assign status.out_busy = rv_ff && !rsp_tready;
   assign rsp_tvalid      = rv_ff;
   assign rsp_tuser       = rhit_ff;
   assign rsp_tdata       = {rdist_ff, ridx_ff};

endmodule

/* rtl/ray_sphere_nearest_pick.sv */
// ----------------------------------------------------------------------------
// ray_sphere_nearest_pick
// Nearest ray-sphere hit over a stream of sphere centres.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   tvalid/tready      tdata centre x,y,z; tlast last_point
//  rsp      out  tvalid/tready      tdata index, distance; tuser hit_found
//  csr      in   csr_we             csr_addr register, csr_wdata value
//
//  Each centre passes through accept, 3 dot-product beats, b squared,
//  det, 37 steps of the bit-serial square root, update.
//  The root unit takes the most steps; one item is in flight at a time.
//  A last beat waits in its update step while an older result is unread.
//  Synchronous active-high reset restores the ray registers and clears state.
// ----------------------------------------------------------------------------
module ray_sphere_nearest_pick (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [95:0]                        req_tdata,  // centre_x, centre_y, centre_z
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,  // nearest_index, nearest_distance
   output logic                               rsp_tuser,  // hit_found
   input  logic                               csr_we,
   input  logic [rsnp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rsnp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rsnp_pkg::cmd_type    cmd;
   rsnp_pkg::status_type status;

   rsnp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsnp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/rsnp_checker.sv */
// ----------------------------------------------------------------------------
// rsnp_checker
// Port-level checks of the nearest ray-sphere pick block.
// ----------------------------------------------------------------------------
module rsnp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // no result comes out of reset
   a_rst_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid) else $error("rsp valid right after reset");

   // a miss carries zero index and distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 40'd0))
      else $error("miss result with nonzero payload");

   // one item in flight: busy right after a beat is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after accept");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind ray_sphere_nearest_pick rsnp_checker u_rsnp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
